// ===== rtl/lru_ot_pkg.sv =====
// Package for the LRU order tracker: sizes, request and status codes,
// controller states and the command group between controller and datapath.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lru_ot_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);

  // Fixed widths of the channel fields.
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    rank_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCESS = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lru_ot_req_if.sv =====
// Request channel of the LRU order tracker: valid, ready and one request item.
// Depends on lru_ot_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lru_ot_req_if;
  import lru_ot_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [KEY_W-1:0]  key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

`default_nettype wire

// ===== rtl/lru_ot_rsp_if.sv =====
// Result channel of the LRU order tracker: valid, ready and one result item.
// Depends on lru_ot_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lru_ot_rsp_if;
  import lru_ot_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [KEY_W-1:0]  evicted_key;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output evicted_key, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input evicted_key, input occupancy,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/lru_ot_ctrl.sv =====
// Controller of the LRU order tracker: sequences capture and execution of
// one item and owns the result valid flag. Depends on lru_ot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lru_ot_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_ready,
  output logic               out_valid,
  output lru_ot_pkg::cmd_t   cmd
);
  import lru_ot_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_valid) state_nxt = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (out_free) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      FSM_EXEC: begin
        cmd.execute = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/lru_ot_dp.sv =====
// Datapath of the LRU order tracker: key slots, valid bits, recency ranks,
// the held count, the request latch and the result register. Depends on lru_ot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lru_ot_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lru_ot_pkg::cmd_t               cmd,
  input  wire logic [lru_ot_pkg::KIND_W-1:0]  in_kind,
  input  wire logic signed [lru_ot_pkg::KEY_W-1:0] in_key,
  output logic [lru_ot_pkg::STATUS_W-1:0]     out_status,
  output logic signed [lru_ot_pkg::KEY_W-1:0] out_evicted_key,
  output logic [lru_ot_pkg::OCC_W-1:0]        out_occupancy
);
  import lru_ot_pkg::*;

  // Request latch.
  logic [KIND_W-1:0] req_kind_r;
  key_t              req_key_r;

  // Slot state.
  key_t              key_r   [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  rank_t             rank_r  [ENTRIES];
  rank_t             rank_nxt[ENTRIES];
  cnt_t              count_r, count_nxt;

  // Result register.
  status_t           status_r, status_nxt;
  logic [KEY_W-1:0]  evk_r, evk_nxt;

  logic [ENTRIES-1:0] hit_vec, evict_vec, free_vec;
  idx_t              hit_idx, evict_idx, free_idx;
  logic              hit_any, evict_any, free_any;
  rank_t             hit_rank;
  logic              wr_en;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid_r[i] && (key_r[i] == req_key_r);
      evict_vec[i] = valid_r[i] && (CNT_W'(rank_r[i]) == count_r - CNT_W'(1));
      free_vec[i]  = !valid_r[i];
    end
  end

  // Lowest-numbered slot wins in each search.
  always_comb begin
    hit_idx   = '0;
    evict_idx = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i])   hit_idx   = IDX_W'(i);
      if (evict_vec[i]) evict_idx = IDX_W'(i);
      if (free_vec[i])  free_idx  = IDX_W'(i);
    end
  end

  assign hit_any   = |hit_vec;
  assign evict_any = |evict_vec;
  assign free_any  = |free_vec;
  assign hit_rank  = rank_r[hit_idx];

  always_comb begin
    valid_nxt  = valid_r;
    rank_nxt   = rank_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    evk_nxt    = '0;
    wr_en      = 1'b0;
    case (kind_t'(req_kind_r))
      KIND_ACCESS: begin
        if (!hit_any) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && (rank_r[i] < hit_rank)) rank_nxt[i] = rank_r[i] + rank_t'(1);
          end
          rank_nxt[hit_idx] = '0;
        end
      end
      KIND_INSERT: begin
        if (hit_any) begin
          status_nxt = ST_PRESENT;
        end else if (count_r >= CNT_W'(ENTRIES) || !free_any) begin
          status_nxt = ST_FULL;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i]) rank_nxt[i] = rank_r[i] + rank_t'(1);
          end
          wr_en               = 1'b1;
          valid_nxt[free_idx] = 1'b1;
          rank_nxt[free_idx]  = '0;
          count_nxt           = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (count_r == '0 || !evict_any) begin
          status_nxt = ST_EMPTY;
        end else begin
          evk_nxt              = KEY_W'(key_r[evict_idx]);
          valid_nxt[evict_idx] = 1'b0;
          rank_nxt[evict_idx]  = '0;
          count_nxt            = count_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else if (cmd.execute) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind_r <= in_kind;
      req_key_r  <= KEY_BITS'($unsigned(in_key));
    end
    if (cmd.execute) begin
      status_r <= status_nxt;
      evk_r    <= evk_nxt;
      if (wr_en) key_r[free_idx] <= req_key_r;
    end
  end

  assign out_status      = status_r;
  assign out_evicted_key = $signed(evk_r);
  assign out_occupancy   = OCC_W'(count_r);

endmodule

`default_nettype wire

// ===== rtl/lru_order_tracker.sv =====
// Timing: an item is captured in idle and executed in the execute state, which waits until
// the result register is free or being emptied; the result is registered. The next item
// is accepted as soon as the controller is back in idle, even while a result waits.
// Reset: synchronous, active low rst_n empties the store, clears ranks and count and
// drops the result valid; no clearing pass is needed, key slots are guarded by valid bits.
`timescale 1ns / 1ps
`default_nettype none

module lru_order_tracker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lru_ot_req_if.sink  in_ch,
  lru_ot_rsp_if.source out_ch
);
  import lru_ot_pkg::*;

  // The controller and the datapath share only this command group. A request is
  // latched when it is taken, and the whole update is made on the execute command,
  // which is only given once the result register is free or being emptied.
  cmd_t cmd;

  lru_ot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // The datapath holds every slot with its key, valid bit and recency rank, where
  // rank zero is the most recent key and rank count-1 the oldest. An access lifts
  // the hit slot to zero and ages the more recent ones, an insert ages all held
  // keys and puts the new one in the lowest free slot, and a remove takes the slot
  // of oldest rank.
  lru_ot_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_ch.kind),
    .in_key          (in_ch.key),
    .out_status      (out_ch.status),
    .out_evicted_key (out_ch.evicted_key),
    .out_occupancy   (out_ch.occupancy)
  );

endmodule

`default_nettype wire

// ===== rtl/lru_ot_checker.sv =====
// Port-level checks for the LRU order tracker, bound to the top level.
// Depends on lru_ot_pkg and on the top level's channel ports.
`timescale 1ns / 1ps
`default_nettype none

module lru_ot_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [lru_ot_pkg::STATUS_W-1:0] out_status,
  input wire logic [lru_ot_pkg::KEY_W-1:0]    out_evicted_key,
  input wire logic [lru_ot_pkg::OCC_W-1:0]    out_occupancy
);
  import lru_ot_pkg::*;

  // Only one item is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= OCC_W'(ENTRIES)))
    else $error("occupancy beyond capacity");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_occupancy == OCC_W'(ENTRIES)))
    else $error("full reported below capacity");

  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_evicted_key == '0))
    else $error("evicted key shown on a failed request");

endmodule

bind lru_order_tracker lru_ot_checker u_lru_ot_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_evicted_key (out_ch.evicted_key),
  .out_occupancy   (out_ch.occupancy)
);

`default_nettype wire
